// ===== src/mags_pkg.sv =====
package mags_pkg;

   // Axis count and derived widths
   localparam int AXES   = 4;
   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

   localparam int STEP_W = 32;
   localparam int GOAL_W = 8;
   localparam int DUR_W  = 16;
   localparam int TIME_W = 32;

   localparam logic [AXES-1:0]  ALL_MASK      = '1;
   localparam logic [DUR_W-1:0] TIMEOUT_RESET = 16'd100;

   // Request opcodes
   localparam logic [2:0] OP_STAGE  = 3'd0;
   localparam logic [2:0] OP_START  = 3'd1;
   localparam logic [2:0] OP_CANCEL = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_REPORT = 3'd4;

   // Response status codes
   localparam logic [3:0] ST_BUSY      = 4'd0;
   localparam logic [3:0] ST_INVALID   = 4'd1;
   localparam logic [3:0] ST_DUP       = 4'd2;
   localparam logic [3:0] ST_WAITING   = 4'd3;
   localparam logic [3:0] ST_READY     = 4'd4;
   localparam logic [3:0] ST_STARTED   = 4'd5;
   localparam logic [3:0] ST_REFUSED   = 4'd6;
   localparam logic [3:0] ST_CANCELLED = 4'd7;
   localparam logic [3:0] ST_TIMEOUT   = 4'd8;
   localparam logic [3:0] ST_COMPLETED = 4'd9;
   localparam logic [3:0] ST_ESTOP     = 4'd10;
   localparam logic [3:0] ST_NONE      = 4'd11;

   // Stepper commands
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_PREPARE = 2'd1;
   localparam logic [1:0] CMD_HOLD    = 2'd2;

   typedef struct packed {
      logic [2:0]               opcode;
      logic [1:0]               axis;
      logic signed [STEP_W-1:0] step_value;
      logic [GOAL_W-1:0]        goal_tag;
      logic [DUR_W-1:0]         move_duration_ms;
      logic                     estop;
   } req_item_type;

   typedef struct packed {
      logic [3:0]               status;
      logic [3:0]               received_mask;
      logic [GOAL_W-1:0]        goal_out;
      logic [DUR_W-1:0]         duration_out;
      logic                     moving;
      logic [1:0]               stepper_command;
      logic [1:0]               target_axis;
      logic signed [STEP_W-1:0] target_out;
      logic                     last;
   } rsp_item_type;

endpackage

// ===== src/mags_if.sv =====
interface mags_req_if;
   import mags_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [2:0]               opcode;
   logic [1:0]               axis;
   logic signed [STEP_W-1:0] step_value;
   logic [GOAL_W-1:0]        goal_tag;
   logic [DUR_W-1:0]         move_duration_ms;
   logic                     estop;

   modport source (
      output valid, opcode, axis, step_value, goal_tag, move_duration_ms, estop,
      input  ready
   );
   modport sink (
      input  valid, opcode, axis, step_value, goal_tag, move_duration_ms, estop,
      output ready
   );
endinterface

interface mags_rsp_if;
   import mags_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [3:0]               status;
   logic [3:0]               received_mask;
   logic [GOAL_W-1:0]        goal_out;
   logic [DUR_W-1:0]         duration_out;
   logic                     moving;
   logic [1:0]               stepper_command;
   logic [1:0]               target_axis;
   logic signed [STEP_W-1:0] target_out;
   logic                     last;

   modport source (
      output valid, status, received_mask, goal_out, duration_out, moving,
             stepper_command, target_axis, target_out, last,
      input  ready
   );
   modport sink (
      input  valid, status, received_mask, goal_out, duration_out, moving,
             stepper_command, target_axis, target_out, last,
      output ready
   );
endinterface

// ===== src/mags_in_stage.sv =====
module mags_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   mags_req_if.sink              req,
   input  logic                  take,
   output logic                  item_valid,
   output mags_pkg::req_item_type item
);
   import mags_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   // Accept a new request when empty or when the held one retires this cycle
   assign req.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req.valid && req.ready) begin
         valid_in                 = 1'b1;
         item_in.opcode           = req.opcode;
         item_in.axis             = req.axis;
         item_in.step_value       = req.step_value;
         item_in.goal_tag         = req.goal_tag;
         item_in.move_duration_ms = req.move_duration_ms;
         item_in.estop            = req.estop;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/mags_core.sv =====
module mags_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [15:0]             csr_write_data,
   input  logic                    item_valid,
   input  mags_pkg::req_item_type  item,
   output logic                    take,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output mags_pkg::rsp_item_type  rsp_item
);
   import mags_pkg::*;

   // Goal slot and motion state
   logic [GOAL_W-1:0] slot_goal_ff, slot_goal_in;
   logic [AXES-1:0]   slot_mask_ff, slot_mask_in;
   logic [DUR_W-1:0]  slot_duration_ff, slot_duration_in;
   logic [TIME_W-1:0] staging_start_ff, staging_start_in;
   logic [TIME_W-1:0] motion_start_ff, motion_start_in;
   logic              needs_motion_ff, needs_motion_in;
   logic [STEP_W-1:0] goal_targets_ff [AXES];
   logic [STEP_W-1:0] goal_targets_in [AXES];
   logic [STEP_W-1:0] axis_positions_ff [AXES];
   logic [STEP_W-1:0] axis_positions_in [AXES];
   logic              motion_active_ff, motion_active_in;
   logic              cancelled_known_ff, cancelled_known_in;
   logic [GOAL_W-1:0] cancelled_goal_ff, cancelled_goal_in;
   logic              completed_known_ff, completed_known_in;
   logic [GOAL_W-1:0] completed_goal_ff, completed_goal_in;
   logic [TIME_W-1:0] now_ms_ff, now_ms_in;
   logic [DUR_W-1:0]  timeout_ff, timeout_in;
   logic [AXIS_W-1:0] beat_ff, beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, res;

   logic              load;
   logic              axis_ok;
   logic [AXIS_W-1:0] axis_idx;
   logic [AXES-1:0]   axis_bit;
   logic [AXES-1:0]   tgt_eq;
   logic [AXES-1:0]   pos_eq;
   logic              at_target;
   logic              any_move;
   logic [TIME_W-1:0] now_next;
   logic [TIME_W-1:0] stage_age;
   logic [TIME_W-1:0] motion_age;
   logic              beat_last;
   logic              fresh;

   // Advance when the result register is free or drains this cycle
   assign load = item_valid && (!rsp_valid_ff || rsp_ready);
   assign take = load && res.last;

   // Per-axis compares, one lane per axis
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         tgt_eq[i] = (goal_targets_ff[i] == item.step_value);
         pos_eq[i] = (goal_targets_ff[i] == axis_positions_ff[i]);
      end
   end

   assign at_target  = &pos_eq;
   assign any_move   = !at_target;
   assign axis_ok    = (int'(item.axis) < AXES);
   assign axis_idx   = AXIS_W'(item.axis);
   assign now_next   = now_ms_ff + 32'd1;
   assign stage_age  = now_next - staging_start_ff;
   assign motion_age = now_next - motion_start_ff;
   assign beat_last  = (beat_ff == AXIS_W'(AXES - 1));
   assign fresh      = (slot_mask_ff == '0);

   always_comb begin
      axis_bit           = '0;
      axis_bit[axis_idx] = 1'b1;
   end

   // Decide the result and the next state for the held request
   always_comb begin
      slot_goal_in       = slot_goal_ff;
      slot_mask_in       = slot_mask_ff;
      slot_duration_in   = slot_duration_ff;
      staging_start_in   = staging_start_ff;
      motion_start_in    = motion_start_ff;
      needs_motion_in    = needs_motion_ff;
      motion_active_in   = motion_active_ff;
      cancelled_known_in = cancelled_known_ff;
      cancelled_goal_in  = cancelled_goal_ff;
      completed_known_in = completed_known_ff;
      completed_goal_in  = completed_goal_ff;
      now_ms_in          = now_ms_ff;
      beat_in            = beat_ff;
      for (int i = 0; i < AXES; i++) begin
         goal_targets_in[i]   = goal_targets_ff[i];
         axis_positions_in[i] = axis_positions_ff[i];
      end
      res        = '0;
      res.status = ST_NONE;
      res.last   = 1'b1;

      unique case (item.opcode)
         OP_STAGE: begin
            if (motion_active_ff) begin
               res.status = ST_BUSY;
            end else if (!axis_ok) begin
               res.status = ST_INVALID;
            end else if (fresh && cancelled_known_ff &&
                         item.goal_tag == cancelled_goal_ff) begin
               res.status = ST_INVALID;
            end else if (fresh && completed_known_ff &&
                         item.goal_tag == completed_goal_ff) begin
               res.status        = ST_DUP;
               res.received_mask = 4'(ALL_MASK);
            end else if (!fresh && slot_goal_ff != item.goal_tag) begin
               res.status = ST_BUSY;
            end else if (!fresh && slot_duration_ff != item.move_duration_ms) begin
               // Drop the slot on a duration mismatch
               slot_goal_in     = '0;
               slot_mask_in     = '0;
               slot_duration_in = '0;
               staging_start_in = '0;
               motion_start_in  = '0;
               needs_motion_in  = 1'b0;
               res.status       = ST_INVALID;
            end else if (!fresh && (slot_mask_ff & axis_bit) != '0) begin
               // Repeated axis: same target is a duplicate, else drop the slot
               res.received_mask = 4'(slot_mask_ff);
               if (tgt_eq[axis_idx]) begin
                  res.status = ST_DUP;
               end else begin
                  slot_goal_in     = '0;
                  slot_mask_in     = '0;
                  slot_duration_in = '0;
                  staging_start_in = '0;
                  motion_start_in  = '0;
                  needs_motion_in  = 1'b0;
                  res.status       = ST_INVALID;
               end
            end else begin
               if (fresh) begin
                  slot_goal_in     = item.goal_tag;
                  slot_duration_in = item.move_duration_ms;
                  staging_start_in = now_ms_ff;
                  motion_start_in  = '0;
                  needs_motion_in  = 1'b0;
               end
               goal_targets_in[axis_idx] = item.step_value;
               slot_mask_in              = slot_mask_ff | axis_bit;
               res.received_mask         = 4'(slot_mask_ff | axis_bit);
               res.status = ((slot_mask_ff | axis_bit) == ALL_MASK) ? ST_READY
                                                                    : ST_WAITING;
            end
         end
         OP_START: begin
            if (beat_ff == '0 && (motion_active_ff || slot_mask_ff != ALL_MASK ||
                                  slot_goal_ff != item.goal_tag)) begin
               res.status        = ST_REFUSED;
               res.received_mask = 4'(slot_mask_ff);
            end else begin
               // Launch on the first beat, then emit one axis per beat
               if (beat_ff == '0) begin
                  needs_motion_in  = any_move;
                  motion_start_in  = now_ms_ff;
                  motion_active_in = 1'b1;
               end
               res.status          = ST_STARTED;
               res.received_mask   = 4'(slot_mask_ff);
               res.duration_out    = slot_duration_ff;
               res.stepper_command = (beat_ff == '0) ? CMD_PREPARE : CMD_NONE;
               res.target_axis     = 2'(beat_ff);
               res.target_out      = goal_targets_ff[beat_ff];
               res.last            = beat_last;
               beat_in             = beat_last ? '0 : beat_ff + AXIS_W'(1);
            end
         end
         OP_CANCEL: begin
            if (!fresh && slot_goal_ff != item.goal_tag) begin
               res.status        = ST_REFUSED;
               res.received_mask = 4'(slot_mask_ff);
            end else begin
               motion_active_in    = 1'b0;
               slot_goal_in        = '0;
               slot_mask_in        = '0;
               slot_duration_in    = '0;
               staging_start_in    = '0;
               motion_start_in     = '0;
               needs_motion_in     = 1'b0;
               cancelled_known_in  = 1'b1;
               cancelled_goal_in   = item.goal_tag;
               res.status          = ST_CANCELLED;
               res.stepper_command = CMD_HOLD;
            end
         end
         OP_TICK: begin
            now_ms_in = now_next;
            if (!fresh && slot_mask_ff != ALL_MASK && !motion_active_ff &&
                stage_age > TIME_W'(timeout_ff)) begin
               // Drop a partial goal that waited too long
               res.status        = ST_TIMEOUT;
               res.received_mask = 4'(slot_mask_ff);
               res.goal_out      = slot_goal_ff;
               res.duration_out  = slot_duration_ff;
               slot_goal_in      = '0;
               slot_mask_in      = '0;
               slot_duration_in  = '0;
               staging_start_in  = '0;
               motion_start_in   = '0;
               needs_motion_in   = 1'b0;
            end else if (motion_active_ff && item.estop) begin
               // Stop motion but keep the full slot for a restart
               motion_active_in    = 1'b0;
               res.status          = ST_ESTOP;
               res.received_mask   = 4'(slot_mask_ff);
               res.stepper_command = CMD_HOLD;
            end else if (motion_active_ff && at_target &&
                         (needs_motion_ff ||
                          motion_age >= TIME_W'(slot_duration_ff))) begin
               completed_known_in  = 1'b1;
               completed_goal_in   = slot_goal_ff;
               motion_active_in    = 1'b0;
               res.status          = ST_COMPLETED;
               res.goal_out        = slot_goal_ff;
               res.stepper_command = CMD_HOLD;
               slot_goal_in        = '0;
               slot_mask_in        = '0;
               slot_duration_in    = '0;
               staging_start_in    = '0;
               motion_start_in     = '0;
               needs_motion_in     = 1'b0;
            end
         end
         OP_REPORT: begin
            if (axis_ok) begin
               axis_positions_in[axis_idx] = item.step_value;
            end
         end
         default: begin
            res.status = ST_NONE;
         end
      endcase

      res.moving = motion_active_in;
   end

   // Result register valid flag and timeout register update
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      timeout_in = csr_write_enable ? csr_write_data : timeout_ff;
   end

   // Control and goal state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_goal_ff       <= '0;
         slot_mask_ff       <= '0;
         slot_duration_ff   <= '0;
         staging_start_ff   <= '0;
         motion_start_ff    <= '0;
         needs_motion_ff    <= 1'b0;
         motion_active_ff   <= 1'b0;
         cancelled_known_ff <= 1'b0;
         cancelled_goal_ff  <= '0;
         completed_known_ff <= 1'b0;
         completed_goal_ff  <= '0;
         now_ms_ff          <= '0;
         beat_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
         timeout_ff         <= TIMEOUT_RESET;
         for (int i = 0; i < AXES; i++) begin
            axis_positions_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         timeout_ff   <= timeout_in;
         if (load) begin
            slot_goal_ff       <= slot_goal_in;
            slot_mask_ff       <= slot_mask_in;
            slot_duration_ff   <= slot_duration_in;
            staging_start_ff   <= staging_start_in;
            motion_start_ff    <= motion_start_in;
            needs_motion_ff    <= needs_motion_in;
            motion_active_ff   <= motion_active_in;
            cancelled_known_ff <= cancelled_known_in;
            cancelled_goal_ff  <= cancelled_goal_in;
            completed_known_ff <= completed_known_in;
            completed_goal_ff  <= completed_goal_in;
            now_ms_ff          <= now_ms_in;
            beat_ff            <= beat_in;
            for (int i = 0; i < AXES; i++) begin
               axis_positions_ff[i] <= axis_positions_in[i];
            end
         end
      end
   end

   // Staged targets and result payload need no reset
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
         for (int i = 0; i < AXES; i++) begin
            goal_targets_ff[i] <= goal_targets_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== src/multi_axis_goal_stager.sv =====
// Multi-axis goal stager.
// req channel: one request per handshake (stage axis, start, cancel,
// millisecond tick, position report). rsp channel: the responses, with
// last set on the final response of each request. csr_write_enable and
// csr_write_data load the staging timeout in milliseconds.
// A request moves into an input register, then one pass of logic builds
// its response into the result register, which drives rsp.
// Every request other than a granted start gives one response, so while
// rsp is not stalled such requests are taken back to back. A granted
// start gives one response per axis from the result register, one per
// cycle while rsp is not stalled, and holds the block until its last
// response; the axis counter in the core steps through the axes.
// When rsp is stalled the result register holds its response; the input
// register still takes one more request and then req.ready drops until
// the result drains.
// Reset is synchronous: the goal slot, positions, clock and flags clear,
// the timeout returns to 100 ms, and both registers empty. Staged targets
// are not cleared; they are only read once written.
module multi_axis_goal_stager (
   input  logic        clock,
   input  logic        reset,
   mags_req_if.sink    req,
   mags_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import mags_pkg::*;

   logic         item_valid;
   logic         take;
   req_item_type item;
   rsp_item_type rsp_item;
   logic         rsp_valid;

   mags_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   mags_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .take             (take),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item)
   );

   // Drive the response channel from the result register
   assign rsp.valid           = rsp_valid;
   assign rsp.status          = rsp_item.status;
   assign rsp.received_mask   = rsp_item.received_mask;
   assign rsp.goal_out        = rsp_item.goal_out;
   assign rsp.duration_out    = rsp_item.duration_out;
   assign rsp.moving          = rsp_item.moving;
   assign rsp.stepper_command = rsp_item.stepper_command;
   assign rsp.target_axis     = rsp_item.target_axis;
   assign rsp.target_out      = rsp_item.target_out;
   assign rsp.last            = rsp_item.last;

`ifndef SYNTHESIS
   // A start run ends on the highest axis
   a_start_ends_last_axis: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_STARTED && rsp.last
      |-> rsp.target_axis == 2'(AXES - 1))
      else $error("start run did not end on the last axis");

   // The prepare command comes only on the first axis, with motion on
   a_prepare_first: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.stepper_command == CMD_PREPARE
      |-> rsp.moving && rsp.target_axis == 2'd0 && rsp.status == ST_STARTED)
      else $error("prepare command outside the first start response");

   // Completed, e-stop and cancelled responses carry a hold command with motion stopped
   a_hold_stops: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == ST_COMPLETED || rsp.status == ST_ESTOP ||
                    rsp.status == ST_CANCELLED)
      |-> !rsp.moving && rsp.stepper_command == CMD_HOLD)
      else $error("stop response with motion still active");
`endif

endmodule
